### rtl/core/kpsc_pkg.sv
// ---------------------------------------------------------------------------
// kpsc_pkg: shared types and constants
// Beat layouts and fixed constants of the Keplerian period and step count.
// ---------------------------------------------------------------------------
package kpsc_pkg;

  // x = p * 2^32 / (1 - e^2) stays below 2^48
  localparam int XW = 48;

  localparam logic [63:0] TWO_PI_Q60      = 64'h6487_ED51_10B4_611A;
  localparam logic [39:0] COUNT_MAX       = 40'hFF_FFFF_FFFF;
  localparam logic [31:0] TIME_STEP_RESET = 32'h0001_0000;

  typedef struct packed {
    logic [31:0] semi_latus_rectum;
    logic [15:0] orbit_eccentricity;
  } kpsc_in_t;

  typedef struct packed {
    logic [63:0] period;
    logic [39:0] step_count;
    logic        saturated;
  } kpsc_out_t;

endpackage

### rtl/core/kpsc_div_cell.sv
// ---------------------------------------------------------------------------
// kpsc_div_cell: one restoring division step
// Takes the next dividend bit, trial-subtracts the divisor and shifts the
// quotient bit in at the bottom of the dividend word.
// ---------------------------------------------------------------------------
module kpsc_div_cell #(
  parameter int DW = 32,
  parameter int NW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] dvsr_i,
  output logic          valid_o,
  output logic [DW-1:0] rem_o,
  output logic [NW-1:0] num_o,
  output logic [DW-1:0] dvsr_o
);

  logic [DW:0]   trial;
  logic          ge;
  logic [DW-1:0] rem_next;
  logic [NW-1:0] num_next;

  always_comb begin
    trial    = {rem_i, num_i[NW-1]};
    ge       = trial >= {1'b0, dvsr_i};
    rem_next = ge ? DW'(trial - {1'b0, dvsr_i}) : trial[DW-1:0];
    num_next = {num_i[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= rem_next;
      num_o  <= num_next;
      dvsr_o <= dvsr_i;
    end
  end

endmodule

### rtl/core/kpsc_sqrt_cell.sv
// ---------------------------------------------------------------------------
// kpsc_sqrt_cell: one restoring square root step
// Brings down two radicand bits, tries 4*root+1 and shifts one root bit in;
// a side word travels along unchanged.
// ---------------------------------------------------------------------------
module kpsc_sqrt_cell #(
  parameter int RW = 32,
  parameter int SW = 48
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            valid_i,
  input  logic [RW:0]     rem_i,
  input  logic [2*RW-1:0] num_i,
  input  logic [RW-1:0]   root_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [RW:0]     rem_o,
  output logic [2*RW-1:0] num_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  logic [RW+2:0]   pull;
  logic [RW+2:0]   trial;
  logic            ge;
  logic [RW:0]     rem_next;
  logic [2*RW-1:0] num_next;
  logic [RW-1:0]   root_next;

  always_comb begin
    pull      = {rem_i, num_i[2*RW-1 -: 2]};
    trial     = {1'b0, root_i, 2'b01};
    ge        = pull >= trial;
    rem_next  = ge ? (RW+1)'(pull - trial) : pull[RW:0];
    num_next  = {num_i[2*RW-3:0], 2'b00};
    root_next = {root_i[RW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= rem_next;
      num_o  <= num_next;
      root_o <= root_next;
      side_o <= side_i;
    end
  end

endmodule

### rtl/core/kpsc_tail.sv
// ---------------------------------------------------------------------------
// kpsc_tail: x^(3/2) and 2*pi scaling
// Five registered stages: split product x*r, shift by the fraction, four
// 32x32 partials with 2*pi in Q60, middle sum, then wide sum and saturation.
// ---------------------------------------------------------------------------
module kpsc_tail #(
  parameter int FRAC_BITS = 16,
  parameter int RW        = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  valid_i,
  input  logic [kpsc_pkg::XW-1:0] x_i,
  input  logic [RW-1:0]         root_i,
  output logic                  valid_o,
  output logic [63:0]           period_o,
  output logic                  sat_o
);

  import kpsc_pkg::*;

  localparam int H  = RW / 2;
  localparam int RH = RW - H;
  localparam int PW = XW + RW;

  logic [4:0]       vld;
  logic [XW+H-1:0]  pa;
  logic [XW+RH-1:0] pb;
  logic [63:0]      y;
  logic             ovf1_s2, ovf1_s3, ovf1_s4;
  logic [63:0]      pp00, pp01, pp10, pp11;
  logic [63:0]      pp00_s4, pp11_s4;
  logic [64:0]      mid;

  logic [PW-1:0]    prod;
  logic [127:0]     yw;
  logic [127:0]     t;
  logic             ovf_all;

  always_comb begin
    prod    = PW'(pa) + (PW'(pb) << H);
    yw      = 128'(prod) >> FRAC_BITS;
    t       = 128'(pp00_s4) + (128'(mid) << 32) + (128'(pp11_s4) << 64);
    ovf_all = ovf1_s4 | (|t[127:124]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa       <= (XW+H)'(x_i) * (XW+H)'(root_i[H-1:0]);
      pb       <= (XW+RH)'(x_i) * (XW+RH)'(root_i[RW-1:H]);
      y        <= yw[63:0];
      ovf1_s2  <= |yw[127:64];
      pp00     <= 64'(y[31:0])  * 64'(TWO_PI_Q60[31:0]);
      pp01     <= 64'(y[31:0])  * 64'(TWO_PI_Q60[63:32]);
      pp10     <= 64'(y[63:32]) * 64'(TWO_PI_Q60[31:0]);
      pp11     <= 64'(y[63:32]) * 64'(TWO_PI_Q60[63:32]);
      ovf1_s3  <= ovf1_s2;
      mid      <= 65'(pp01) + 65'(pp10);
      pp00_s4  <= pp00;
      pp11_s4  <= pp11;
      ovf1_s4  <= ovf1_s3;
      period_o <= ovf_all ? '1 : t[123:60];
      sat_o    <= ovf_all;
    end
  end

  assign valid_o = vld[4];

endmodule

### rtl/core/keplerian_period_and_step_count.sv
// ---------------------------------------------------------------------------
// keplerian_period_and_step_count: orbital period and step count
// x = p/(1-e^2), T = 2*pi*x^(3/2), count = ceil(T/dt), all fixed point.
// ---------------------------------------------------------------------------
//  channel | signals                    | beat
//  in      | in_valid/in_ready/in_data  | p (Q16.16), e (Q0.16)
//  out     | out_valid/out_ready/out_data | T (Q48.16), count, saturated flag
//  cfg     | cfg_we/cfg_wdata           | time step dt
//
// One beat per cycle sustained unless a result waits on out_ready low. A
// beat passes the input stage, 48 divide cells, RW root cells, five
// multiply stages, 64 divide cells for the count and the output register.
// The whole chain holds while a result waits on out_ready low.
// Reset clears the valid chain and loads dt = 1.0.
// ---------------------------------------------------------------------------
module keplerian_period_and_step_count #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  kpsc_pkg::kpsc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kpsc_pkg::kpsc_out_t out_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);

  import kpsc_pkg::*;

  localparam int RW = (XW + FRAC_BITS + 1) / 2;
  localparam int DC = 64;

  logic        en;
  logic [31:0] time_step;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TIME_STEP_RESET;
    end else if (cfg_we) begin
      time_step <= cfg_wdata;
    end
  end

  // input stage: q = 2^32 - e^2
  logic        v0;
  logic [32:0] q0;
  logic [32:0] rem0;
  logic [XW-1:0] num0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q0   <= 33'h1_0000_0000 - {1'b0, 32'(in_data.orbit_eccentricity)
                                       * 32'(in_data.orbit_eccentricity)};
      rem0 <= 33'(in_data.semi_latus_rectum[31:16]);
      num0 <= {in_data.semi_latus_rectum[15:0], 32'h0};
    end
  end

  // x divider chain
  logic          dv  [0:XW];
  logic [32:0]   drem[0:XW];
  logic [XW-1:0] dnum[0:XW];
  logic [32:0]   ddiv[0:XW];

  assign dv[0]   = v0;
  assign drem[0] = rem0;
  assign dnum[0] = num0;
  assign ddiv[0] = q0;

  for (genvar i = 0; i < XW; i++) begin : g_xdiv
    kpsc_div_cell #(.DW(33), .NW(XW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .valid_i(dv[i]), .rem_i(drem[i]), .num_i(dnum[i]), .dvsr_i(ddiv[i]),
      .valid_o(dv[i+1]), .rem_o(drem[i+1]), .num_o(dnum[i+1]), .dvsr_o(ddiv[i+1])
    );
  end

  // root chain on x * 2^F, carrying x alongside
  logic            sv   [0:RW];
  logic [RW:0]     srem [0:RW];
  logic [2*RW-1:0] snum [0:RW];
  logic [RW-1:0]   sroot[0:RW];
  logic [XW-1:0]   sx   [0:RW];

  assign sv[0]    = dv[XW];
  assign srem[0]  = '0;
  assign snum[0]  = (2*RW)'({dnum[XW], FRAC_BITS'(0)});
  assign sroot[0] = '0;
  assign sx[0]    = dnum[XW];

  for (genvar i = 0; i < RW; i++) begin : g_root
    kpsc_sqrt_cell #(.RW(RW), .SW(XW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .valid_i(sv[i]), .rem_i(srem[i]), .num_i(snum[i]), .root_i(sroot[i]),
      .side_i(sx[i]),
      .valid_o(sv[i+1]), .rem_o(srem[i+1]), .num_o(snum[i+1]), .root_o(sroot[i+1]),
      .side_o(sx[i+1])
    );
  end

  logic        tv;
  logic [63:0] t_period;
  logic        t_sat;

  kpsc_tail #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_tail (
    .clk(clk), .rst(rst), .en(en),
    .valid_i(sv[RW]), .x_i(sx[RW]), .root_i(sroot[RW]),
    .valid_o(tv), .period_o(t_period), .sat_o(t_sat)
  );

  // count divider chain; the period rides in the dividend word as it
  // shifts out, so keep a copy beside the saturation flag
  logic        cv  [0:DC];
  logic [31:0] crem[0:DC];
  logic [63:0] cnum[0:DC];
  logic [31:0] cdiv[0:DC];
  logic [63:0] cper[0:DC];
  logic        csat[0:DC];

  assign cv[0]   = tv;
  assign crem[0] = '0;
  assign cnum[0] = t_period;
  assign cdiv[0] = time_step;
  assign cper[0] = t_period;
  assign csat[0] = t_sat;

  for (genvar i = 0; i < DC; i++) begin : g_cdiv
    kpsc_div_cell #(.DW(32), .NW(64)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .valid_i(cv[i]), .rem_i(crem[i]), .num_i(cnum[i]), .dvsr_i(cdiv[i]),
      .valid_o(cv[i+1]), .rem_o(crem[i+1]), .num_o(cnum[i+1]), .dvsr_o(cdiv[i+1])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        cper[i+1] <= cper[i];
        csat[i+1] <= csat[i];
      end
    end
  end

  // output register: round up, saturate
  logic [64:0] count_up;
  logic        count_ovf;
  logic        dt_zero;

  always_comb begin
    count_up  = 65'(cnum[DC]) + 65'(crem[DC] != '0);
    count_ovf = count_up > 65'(COUNT_MAX);
    dt_zero   = cdiv[DC] == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cv[DC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.period     <= cper[DC];
      out_data.step_count <= (dt_zero || count_ovf) ? COUNT_MAX : count_up[39:0];
      out_data.saturated  <= csat[DC] || dt_zero || count_ovf;
    end
  end

  a_dt_zero_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && time_step == '0 |-> out_data.saturated &&
                                     out_data.step_count == COUNT_MAX)
    else $error("zero time step did not saturate the count");

  a_unit_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && time_step == 32'd1 && !out_data.saturated |->
      {24'h0, out_data.step_count} == out_data.period)
    else $error("unit time step count differs from period");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

### tb/keplerian_period_and_step_count_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// keplerian_period_and_step_count_tb: self-checking regression
// Drives orbit beats through the period and step-count pipe. A local
// fixed-point predictor works out each result not typed in, and every
// output beat is compared field by field. Time step changes between phases.
// Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module keplerian_period_and_step_count_tb;
  import kpsc_pkg::*;

  localparam int FRAC        = 16;
  localparam int DRAIN       = 170;
  localparam int CYCLE_LIMIT = 600000;
  localparam int N_DIRECTED  = 14;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  kpsc_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  kpsc_out_t out_data;
  logic      cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  logic [31:0] step_len = TIME_STEP_RESET;
  kpsc_out_t   period_due[$];
  int          errors = 0;
  int          cycles = 0;
  int          burst_left = 0;
  int          stall_mode = 0;

  typedef struct {
    logic [31:0] p;
    logic [15:0] e;
    bit          typed;
    kpsc_out_t   res;
  } orbit_row_t;

  orbit_row_t orbit_rows[N_DIRECTED];

  keplerian_period_and_step_count uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic kpsc_out_t orbit_period(logic [31:0] p, logic [15:0] e,
                                             logic [31:0] dt);
    logic [32:0]  q;
    logic [63:0]  x, r, cand, per, cnt;
    logic [127:0] rad, y, t;
    logic         sat;
    kpsc_out_t    res;
    sat = 1'b0;
    q = 33'h1_0000_0000 - 33'(e) * 33'(e);
    x = {p, 32'b0} / 64'(q);
    rad = {64'b0, x} << FRAC;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = r | (64'b1 << b);
      if ({64'b0, cand} * {64'b0, cand} <= rad) r = cand;
    end
    y = ({64'b0, x} * {64'b0, r}) >> FRAC;
    if (y[127:64] != 0) begin
      sat = 1'b1;
      per = '1;
    end else begin
      t = {64'b0, y[63:0]} * {64'b0, TWO_PI_Q60};
      if (t[127:124] != 0) begin
        sat = 1'b1;
        per = '1;
      end else begin
        per = t[123:60];
      end
    end
    if (dt == 0) begin
      sat = 1'b1;
      cnt = 64'(COUNT_MAX);
    end else begin
      cnt = per / 64'(dt);
      if (per % 64'(dt) != 0) cnt = cnt + 1;
      if (cnt > 64'(COUNT_MAX)) begin
        sat = 1'b1;
        cnt = 64'(COUNT_MAX);
      end
    end
    res.period = per;
    res.step_count = cnt[39:0];
    res.saturated = sat;
    return res;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  // send one beat; burst/gap decided after acceptance
  task automatic send_orbit(logic [31:0] p, logic [15:0] e, bit typed, kpsc_out_t res);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= '{semi_latus_rectum: p, orbit_eccentricity: e};
    do @(posedge clk); while (!(in_valid && in_ready));
    period_due.push_back(typed ? res : orbit_period(p, e, step_len));
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic settle;
    @(negedge clk);
    in_valid <= 1'b0;
    while (period_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_step(logic [31:0] v);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    step_len = v;
  endtask

  // random orbit with a spread of magnitudes; extremes now and then
  task automatic send_random;
    logic [31:0] p;
    logic [15:0] e;
    p = $urandom >> $urandom_range(0, 31);
    e = 16'($urandom) >> $urandom_range(0, 15);
    case ($urandom_range(0, 9))
      0: p = '1;
      1: e = '1;
      2: e = 16'hFFFF - 16'($urandom_range(0, 255));
      default: ;
    endcase
    send_orbit(p, e, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("keplerian_period_and_step_count regression: fail");
      $finish;
    end
  end

  // receiver stalls in modes: none, light, heavy
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    kpsc_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (period_due.size() == 0) begin
        $display("unexpected result beat (cycle %0d)", cycles);
        errors++;
      end else begin
        want = period_due.pop_front();
        if (out_data.period !== want.period)
          report("period", out_data.period, want.period);
        if (out_data.step_count !== want.step_count)
          report("step_count", 64'(out_data.step_count), 64'(want.step_count));
        if (out_data.saturated !== want.saturated)
          report("saturated", 64'(out_data.saturated), 64'(want.saturated));
      end
    end
  end

  initial begin
    kpsc_out_t zero_res, sat_res;
    zero_res = '{period: '0, step_count: '0, saturated: 1'b0};
    sat_res  = '{period: '1, step_count: COUNT_MAX, saturated: 1'b1};
    orbit_rows[0]  = '{32'h0000_0000, 16'h0000, 1'b1, zero_res};
    orbit_rows[1]  = '{32'h0000_0000, 16'hFFFF, 1'b1, zero_res};
    orbit_rows[2]  = '{32'hFFFF_FFFF, 16'hFFFF, 1'b1, sat_res};
    orbit_rows[3]  = '{32'hFFFF_FFFF, 16'h0000, 1'b0, '0};
    orbit_rows[4]  = '{32'h0001_0000, 16'h0000, 1'b0, '0};
    orbit_rows[5]  = '{32'h0000_0001, 16'h0000, 1'b0, '0};
    orbit_rows[6]  = '{32'h0000_0001, 16'hFFFF, 1'b0, '0};
    orbit_rows[7]  = '{32'h0001_0000, 16'h8000, 1'b0, '0};
    orbit_rows[8]  = '{32'hAAAA_AAAA, 16'h5555, 1'b0, '0};
    orbit_rows[9]  = '{32'h5555_5555, 16'hAAAA, 1'b0, '0};
    orbit_rows[10] = '{32'h8000_0000, 16'hFF00, 1'b0, '0};
    orbit_rows[11] = '{32'h0100_0000, 16'hFFF0, 1'b0, '0};
    orbit_rows[12] = '{32'h00FF_FFFF, 16'h0001, 1'b0, '0};
    orbit_rows[13] = '{32'h7FFF_FFFF, 16'h7FFF, 1'b0, '0};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows at the reset time step
    foreach (orbit_rows[i])
      send_orbit(orbit_rows[i].p, orbit_rows[i].e, orbit_rows[i].typed, orbit_rows[i].res);
    repeat (230) send_random();

    write_step(32'h0000_0001);
    repeat (230) send_random();
    write_step(32'h0000_0000);
    repeat (230) send_random();
    write_step(32'hFFFF_FFFF);
    repeat (230) send_random();
    write_step($urandom_range(1, 32'h00FF_FFFF));
    repeat (230) send_random();
    write_step($urandom);
    repeat (230) send_random();

    settle();
    if (errors == 0 && period_due.size() == 0) begin
      $display("keplerian_period_and_step_count regression: pass");
    end else begin
      $display("keplerian_period_and_step_count regression: fail");
    end
    $finish;
  end

endmodule

### keplerian_period_and_step_count.f
rtl/core/kpsc_pkg.sv
rtl/core/kpsc_div_cell.sv
rtl/core/kpsc_sqrt_cell.sv
rtl/core/kpsc_tail.sv
rtl/core/keplerian_period_and_step_count.sv
tb/keplerian_period_and_step_count_tb.sv
